// ----- hdl/cacs_pkg.sv -----
// ----------------------------------------------------------------------------
// cacs_pkg
// shared widths, rule constants and types for the cave automaton column step
// ----------------------------------------------------------------------------
package cacs_pkg;

    localparam int COL_W            = 64;   // cells per column word
    localparam int CFG_W            = 7;    // widest configuration register
    localparam int ROWS_W           = 7;
    localparam int LIMIT_W          = 4;
    localparam int PASS_W           = 4;
    localparam int SEEN_W           = 2;
    localparam int WIN_COLS         = 5;    // columns c-2 .. c+2
    localparam int HIST_DEPTH       = 4;
    localparam int DEFAULT_MAX_ROWS = 64;

    // configuration register indexes
    localparam logic REG_ROWS_IN_USE      = 1'b0;
    localparam logic REG_EARLY_PASS_LIMIT = 1'b1;

    // reset values of the registers
    localparam logic [ROWS_W-1:0]  ROWS_IN_USE_RST      = 7'd64;
    localparam logic [LIMIT_W-1:0] EARLY_PASS_LIMIT_RST = 4'd4;

    // rule constants
    localparam logic [3:0]        CORE_CELLS     = 4'd9;
    localparam logic [4:0]        RING_CELLS     = 5'd16;
    localparam logic [3:0]        WALL_LIMIT     = 4'd5;
    localparam logic [4:0]        OPEN_WALLS_MIN = 5'd2;
    localparam logic [PASS_W-1:0] PASS_MAX       = 4'd15;
    localparam logic [SEEN_W-1:0] SEEN_MAX       = 2'd2;

    typedef logic [COL_W-1:0] column_t;

    // control handed to the column evaluator
    typedef struct packed {
        column_t row_mask;
        logic    early;
    } eval_ctl_t;

endpackage

// ----- hdl/cave_automaton_column_step.sv -----
// ----------------------------------------------------------------------------
// cave_automaton_column_step
// one pass of the 4-5 cave automaton, streamed one grid column per transfer
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                    | tlast
//  ---------+-----------+--------------------------+-----------
//  s_       | in        | [63:0] column_cells      | last_column
//  m_       | out       | [63:0] next_column_cells | frame_end
//  cfg_     | in        | [6:0] register value     | -
//
//  ordinary columns take one input transfer per clock while the output is free;
//  the job register and then the output register put the result of the column
//  two places back on m_
//  the last column of a frame emits up to three results through the single
//  column evaluator, one per cycle while the output is free, so it holds the
//  input until it emits the final one; a stalled output holds in the output
//  register; the job register keeps the window, so the input side stays open
//  as long as the job can retire; reset clears history, pass count, job and
//  output valid; registers go to their reset values
//
module cave_automaton_column_step #(
    parameter int MAX_ROWS = cacs_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [cacs_pkg::CFG_W-1:0] cfg_wdata,
    // input columns
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cacs_pkg::COL_W-1:0] s_tdata,   // [63:0] column_cells
    input  logic                       s_tlast,   // last_column
    // result columns
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cacs_pkg::COL_W-1:0] m_tdata,   // [63:0] next_column_cells
    output logic                       m_tlast    // frame_end
);

    // configuration registers
    logic [cacs_pkg::ROWS_W-1:0]  rows_in_use_reg;
    logic [cacs_pkg::LIMIT_W-1:0] early_pass_limit_reg;

    // frame state
    cacs_pkg::column_t            hist_reg [cacs_pkg::HIST_DEPTH];  // newest first
    cacs_pkg::column_t            hist_next [cacs_pkg::HIST_DEPTH];
    logic [cacs_pkg::SEEN_W-1:0]  columns_seen_reg, columns_seen_next;
    logic [cacs_pkg::PASS_W-1:0]  pass_count_reg, pass_count_next;

    // job register: window of the next result and how many are left
    logic                         job_valid_reg, job_valid_next;
    logic [1:0]                   job_left_reg, job_left_next;
    logic                         job_last_reg, job_last_next;
    logic                         job_early_reg, job_early_next;
    cacs_pkg::column_t            job_win_reg [cacs_pkg::WIN_COLS];
    cacs_pkg::column_t            job_win_next [cacs_pkg::WIN_COLS];
    cacs_pkg::column_t            load_win [cacs_pkg::WIN_COLS];

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    cacs_pkg::column_t            m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;

    logic [cacs_pkg::ROWS_W-1:0]  active_rows;
    cacs_pkg::column_t            row_mask;
    cacs_pkg::column_t            col_in;
    logic                         early_now;
    logic                         accept;
    logic                         out_free;
    logic                         emit;
    logic                         job_done;
    logic [1:0]                   load_count;
    cacs_pkg::eval_ctl_t          eval_ctl;
    cacs_pkg::column_t            eval_col;

    // rows past the build limit count as walls
    assign active_rows = (rows_in_use_reg > cacs_pkg::ROWS_W'(MAX_ROWS))
                       ? cacs_pkg::ROWS_W'(MAX_ROWS) : rows_in_use_reg;

    always_comb begin
        for (int i = 0; i < cacs_pkg::COL_W; i++) begin
            row_mask[i] = cacs_pkg::ROWS_W'(i) < active_rows;
        end
    end

    assign col_in    = s_tdata & row_mask;
    assign early_now = pass_count_reg < early_pass_limit_reg;

    // handshake: the job retires its final result in the same cycle as a new load
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = job_valid_reg && out_free;
    assign job_done = emit && (job_left_reg == 2'd1);
    assign s_tready = !job_valid_reg || job_done;
    assign accept   = s_tvalid && s_tready;

    // results caused by this column: flush on last, else one once two are held
    always_comb begin
        if (s_tlast) begin
            load_count = columns_seen_reg + 2'd1;
        end else if (columns_seen_reg >= cacs_pkg::SEEN_MAX) begin
            load_count = 2'd1;
        end else begin
            load_count = 2'd0;
        end
    end

    // first window: centre two columns back, or fewer in a short frame
    always_comb begin
        load_win[0] = hist_reg[3];
        load_win[1] = hist_reg[2];
        load_win[2] = hist_reg[1];
        load_win[3] = hist_reg[0];
        load_win[4] = col_in;
        if (s_tlast) begin
            case (columns_seen_reg)
                2'd0: begin
                    load_win[0] = hist_reg[1];
                    load_win[1] = hist_reg[0];
                    load_win[2] = col_in;
                    load_win[3] = '0;
                    load_win[4] = '0;
                end
                2'd1: begin
                    load_win[0] = hist_reg[2];
                    load_win[1] = hist_reg[1];
                    load_win[2] = hist_reg[0];
                    load_win[3] = col_in;
                    load_win[4] = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // job register
    always_comb begin
        job_valid_next = job_valid_reg;
        job_left_next  = job_left_reg;
        job_last_next  = job_last_reg;
        job_early_next = job_early_reg;
        job_win_next   = job_win_reg;
        if (accept) begin
            job_valid_next = load_count != 2'd0;
            job_left_next  = load_count;
            job_last_next  = s_tlast;
            job_early_next = early_now;
            job_win_next   = load_win;
        end else if (emit) begin
            // slide the window one column to the right, walls beyond the frame
            job_valid_next = !job_done;
            job_left_next  = job_left_reg - 2'd1;
            for (int j = 0; j < cacs_pkg::WIN_COLS - 1; j++) begin
                job_win_next[j] = job_win_reg[j+1];
            end
            job_win_next[cacs_pkg::WIN_COLS-1] = '0;
        end
    end

    // column history, frame counters
    always_comb begin
        hist_next         = hist_reg;
        columns_seen_next = columns_seen_reg;
        pass_count_next   = pass_count_reg;
        if (accept) begin
            if (s_tlast) begin
                for (int j = 0; j < cacs_pkg::HIST_DEPTH; j++) begin
                    hist_next[j] = '0;
                end
                columns_seen_next = '0;
                if (pass_count_reg != cacs_pkg::PASS_MAX) begin
                    pass_count_next = pass_count_reg + 1'b1;
                end
            end else begin
                for (int j = cacs_pkg::HIST_DEPTH - 1; j > 0; j--) begin
                    hist_next[j] = hist_reg[j-1];
                end
                hist_next[0] = col_in;
                if (columns_seen_reg < cacs_pkg::SEEN_MAX) begin
                    columns_seen_next = columns_seen_reg + 2'd1;
                end
            end
        end
    end

    // single shared evaluator on the job window
    assign eval_ctl.row_mask = row_mask;
    assign eval_ctl.early    = job_early_reg;

    cacs_col_eval #(
        .MAX_ROWS (MAX_ROWS)
    ) u_col_eval (
        .win      (job_win_reg),
        .ctl      (eval_ctl),
        .next_col (eval_col)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = eval_col;
            m_tlast_next  = job_last_reg && (job_left_reg == 2'd1);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg      <= cacs_pkg::ROWS_IN_USE_RST;
            early_pass_limit_reg <= cacs_pkg::EARLY_PASS_LIMIT_RST;
            for (int j = 0; j < cacs_pkg::HIST_DEPTH; j++) begin
                hist_reg[j] <= '0;
            end
            columns_seen_reg     <= '0;
            pass_count_reg       <= '0;
            job_valid_reg        <= 1'b0;
            job_left_reg         <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    cacs_pkg::REG_ROWS_IN_USE: begin
                        rows_in_use_reg <= cfg_wdata[cacs_pkg::ROWS_W-1:0];
                    end
                    cacs_pkg::REG_EARLY_PASS_LIMIT: begin
                        early_pass_limit_reg <= cfg_wdata[cacs_pkg::LIMIT_W-1:0];
                    end
                endcase
            end
            hist_reg         <= hist_next;
            columns_seen_reg <= columns_seen_next;
            pass_count_reg   <= pass_count_next;
            job_valid_reg    <= job_valid_next;
            job_left_reg     <= job_left_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        job_last_reg  <= job_last_next;
        job_early_reg <= job_early_next;
        job_win_reg   <= job_win_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // a live job always has results left
    a_job_left: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (job_left_reg != 2'd0))
        else $error("job register valid with no results left");

    // no new column while the job still owes more than its final result
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && job_left_reg != 2'd1) |-> !s_tready)
        else $error("input open while a flush is in progress");

    // the last column of a frame restarts the column count
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (columns_seen_reg == '0))
        else $error("column count not cleared after frame end");

endmodule

// ----- hdl/cacs_col_eval.sv -----
// ----------------------------------------------------------------------------
// cacs_col_eval
// next state of one centre column from a five-column window
// ----------------------------------------------------------------------------
module cacs_col_eval #(
    parameter int MAX_ROWS = cacs_pkg::DEFAULT_MAX_ROWS
) (
    input  cacs_pkg::column_t win [cacs_pkg::WIN_COLS],
    input  cacs_pkg::eval_ctl_t ctl,
    output cacs_pkg::column_t next_col
);

    localparam int PAD_W = cacs_pkg::COL_W + 4;

    logic [PAD_W-1:0]  pad [cacs_pkg::WIN_COLS];
    cacs_pkg::column_t raw_col;

    // two wall rows below row zero and above the top row
    always_comb begin
        for (int j = 0; j < cacs_pkg::WIN_COLS; j++) begin
            pad[j] = {2'b00, win[j] & ctl.row_mask, 2'b00};
        end
    end

    for (genvar r = 0; r < cacs_pkg::COL_W; r++) begin : g_row
        if (r < MAX_ROWS) begin : g_cell
            logic [8:0]  core_bits;
            logic [15:0] ring_bits;
            logic [3:0]  core_open;
            logic [4:0]  ring_open;
            logic [3:0]  walls3;
            logic [4:0]  total;

            assign core_bits = {pad[1][r+3:r+1], pad[2][r+3:r+1], pad[3][r+3:r+1]};
            assign ring_bits = {pad[0][r+4:r], pad[4][r+4:r],
                                pad[1][r], pad[1][r+4], pad[2][r], pad[2][r+4],
                                pad[3][r], pad[3][r+4]};
            assign core_open = 4'($countones(core_bits));
            assign ring_open = 5'($countones(ring_bits));
            assign walls3    = cacs_pkg::CORE_CELLS - core_open;
            assign total     = {1'b0, walls3} + (cacs_pkg::RING_CELLS - ring_open);

            assign raw_col[r] = (ctl.early && walls3 < cacs_pkg::WALL_LIMIT)
                              ? (total > cacs_pkg::OPEN_WALLS_MIN)
                              : (walls3 < cacs_pkg::WALL_LIMIT);
        end else begin : g_unused
            assign raw_col[r] = 1'b0;
        end
    end

    assign next_col = raw_col & ctl.row_mask;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streamed cave automaton column step
// ----------------------------------------------------------------------------
//
// columns are streamed into u_top frame by frame; every accepted input column
// is run through a behavioral copy of the automaton (history, column count,
// pass count, registers), and the result columns it implies are queued
// each result transfer is checked field by field against the oldest queued
// column; a directed part covers frame lengths of one, two, three and five columns, the
// row count extremes (zero, one, full, above full) and the early rule forced
// on and off; the random part streams frames of random length and density
// under random register settings, random gaps and random output stalls
//
module testbench;

    localparam int CLK_HALF      = 4;      // 8 ns clock
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 4;      // output register plus evaluator slack
    localparam int IDLE_LIMIT    = 2000;   // cycles with no transfer at all

    // fill patterns for random columns, 1 is open
    typedef enum int {
        DENSITY_HALF,
        DENSITY_SPARSE,
        DENSITY_DENSE,
        DENSITY_PACKED
    } density_t;

    // one expected result column
    typedef struct packed {
        cacs_pkg::column_t cells;
        logic              frame_end;
    } result_column_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic                          cfg_addr;
    logic [cacs_pkg::CFG_W-1:0]    cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cacs_pkg::COL_W-1:0]    s_tdata;     // [63:0] column_cells
    logic                          s_tlast;     // last_column
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cacs_pkg::COL_W-1:0]    m_tdata;     // [63:0] next_column_cells
    logic                          m_tlast;     // frame_end

    // behavioral copy of the block state and registers
    logic [cacs_pkg::HIST_DEPTH-1:0][cacs_pkg::COL_W-1:0] history;  // newest at 0
    logic [cacs_pkg::SEEN_W-1:0]                          seen;
    logic [cacs_pkg::PASS_W-1:0]                          passes;
    logic [cacs_pkg::ROWS_W-1:0]                          rows_reg;
    logic [cacs_pkg::LIMIT_W-1:0]                         limit_reg;

    result_column_t pending_columns[$];
    result_column_t due_column;

    int mismatches     = 0;
    int columns_sent   = 0;
    int send_gap_max   = 0;
    int recv_stall_max = 0;
    int stall_left     = 0;
    int idle_cycles;

    cave_automaton_column_step u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // automaton rule for one column
    // ------------------------------------------------------------------------

    // win[0..4] holds columns c-2 .. c+2; anything outside rows is a wall
    function automatic cacs_pkg::column_t evolve_column(
        input logic [cacs_pkg::WIN_COLS-1:0][cacs_pkg::COL_W-1:0] win,
        input int rows, input bit early);
        cacs_pkg::column_t next_cells;
        int      open3;
        int      open5;
        int      walls3;
        int      rr;
        bit      open_bit;
        next_cells = '0;
        for (int r = 0; r < rows; r++) begin
            open3 = 0;
            open5 = 0;
            for (int dc = 0; dc < cacs_pkg::WIN_COLS; dc++) begin
                for (int dr = -2; dr <= 2; dr++) begin
                    rr       = r + dr;
                    open_bit = (rr >= 0 && rr < rows) ? win[dc][rr] : 1'b0;
                    open5 += open_bit;
                    if (dc >= 1 && dc <= 3 && dr >= -1 && dr <= 1)
                        open3 += open_bit;
                end
            end
            walls3 = cacs_pkg::CORE_CELLS - open3;
            // early passes pull in the walls of the outer ring
            if (early && walls3 < cacs_pkg::WALL_LIMIT)
                next_cells[r] = (walls3 + cacs_pkg::RING_CELLS - (open5 - open3))
                                > cacs_pkg::OPEN_WALLS_MIN;
            else
                next_cells[r] = walls3 < cacs_pkg::WALL_LIMIT;
        end
        return next_cells;
    endfunction

    // advance the behavioral state by one accepted column and queue its results
    task automatic predict_transfer(input cacs_pkg::column_t cells, input logic last);
        logic [7:0][cacs_pkg::COL_W-1:0]                      w;
        logic [cacs_pkg::WIN_COLS-1:0][cacs_pkg::COL_W-1:0] win;
        result_column_t                                      res;
        cacs_pkg::column_t                                   mask;
        cacs_pkg::column_t                                   x;
        int                                                  rows;
        int                                                  n;
        int                                                  first;
        int                                                  stop;
        bit                                                  early;
        rows  = (rows_reg > cacs_pkg::DEFAULT_MAX_ROWS) ? cacs_pkg::DEFAULT_MAX_ROWS
                                                        : int'(rows_reg);
        mask  = (rows >= cacs_pkg::COL_W) ? '1 : ((64'd1 << rows) - 64'd1);
        x     = cells & mask;
        early = passes < limit_reg;
        n     = seen;
        // frame order: oldest history column first, the new column at 4
        w    = '0;
        w[0] = history[3];
        w[1] = history[2];
        w[2] = history[1];
        w[3] = history[0];
        w[4] = x;
        if (last) begin
            first = 4 - n;
            stop  = 4;
        end else if (n >= 2) begin
            first = 2;
            stop  = 2;
        end else begin
            first = 1;
            stop  = 0;
        end
        for (int k = first; k <= stop; k++) begin
            for (int j = 0; j < cacs_pkg::WIN_COLS; j++)
                win[j] = w[k - 2 + j];
            res.cells     = evolve_column(win, rows, early) & mask;
            res.frame_end = last && (k == stop);
            pending_columns.push_back(res);
        end
        if (last) begin
            history = '0;
            seen    = '0;
            if (passes < cacs_pkg::PASS_MAX)
                passes = passes + 1'b1;
        end else begin
            history = {history[2:0], x};
            seen    = (n < cacs_pkg::SEEN_MAX) ? cacs_pkg::SEEN_W'(n + 1)
                                               : cacs_pkg::SEEN_MAX;
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // entered and left at a falling edge; tvalid stays high on return so a
    // back-to-back column never drops it within the same step
    task automatic send_column(input cacs_pkg::column_t cells, input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_transfer(cells, last);
        columns_sent++;
        @(negedge aclk);
    endtask

    // hold off the input until every queued result has come out
    task automatic wait_for_results(input int settle);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_columns.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_register(input logic addr, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= cacs_pkg::CFG_W'(value);
        if (addr == cacs_pkg::REG_ROWS_IN_USE)
            rows_reg = cacs_pkg::ROWS_W'(value);
        else
            limit_reg = cacs_pkg::LIMIT_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic cacs_pkg::column_t random_column(input density_t density);
        cacs_pkg::column_t a;
        cacs_pkg::column_t b;
        cacs_pkg::column_t c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            DENSITY_SPARSE: return a & b;
            DENSITY_DENSE:  return a | b;
            DENSITY_PACKED: return a | b | c;
            default:        return a;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one, two and five column frames under the reset registers, early rule on
    task automatic test_short_frames();
        send_column('1, 1'b1);
        wait_for_results(SETTLE_CYCLES);
        send_column('1, 1'b0);
        send_column('0, 1'b1);
        wait_for_results(SETTLE_CYCLES);
        send_column('1, 1'b0);
        send_column({32{2'b10}}, 1'b0);
        send_column({32{2'b01}}, 1'b0);
        send_column(random_column(DENSITY_DENSE), 1'b0);
        send_column(64'hF0F0_F0F0_0F0F_0F0F, 1'b1);
        wait_for_results(SETTLE_CYCLES);
    endtask

    // no rows at all, a single row, and a count above the column width
    task automatic test_row_count_extremes();
        write_register(cacs_pkg::REG_ROWS_IN_USE, 0);
        send_column('1, 1'b0);
        send_column('1, 1'b0);
        send_column(random_column(DENSITY_HALF), 1'b1);
        wait_for_results(SETTLE_CYCLES);
        write_register(cacs_pkg::REG_ROWS_IN_USE, 1);
        send_column('1, 1'b0);
        send_column('1, 1'b0);
        send_column('1, 1'b1);
        wait_for_results(SETTLE_CYCLES);
        write_register(cacs_pkg::REG_ROWS_IN_USE, 127);
        send_column(random_column(DENSITY_PACKED), 1'b0);
        send_column(random_column(DENSITY_PACKED), 1'b1);
        wait_for_results(SETTLE_CYCLES);
        write_register(cacs_pkg::REG_ROWS_IN_USE, 64);
    endtask

    // early rule forced on for every pass, then never used
    task automatic test_early_limit_extremes();
        write_register(cacs_pkg::REG_EARLY_PASS_LIMIT, 15);
        send_column(random_column(DENSITY_DENSE), 1'b0);
        send_column(random_column(DENSITY_PACKED), 1'b0);
        send_column(random_column(DENSITY_DENSE), 1'b1);
        wait_for_results(SETTLE_CYCLES);
        write_register(cacs_pkg::REG_EARLY_PASS_LIMIT, 0);
        send_column(random_column(DENSITY_DENSE), 1'b0);
        send_column(random_column(DENSITY_PACKED), 1'b0);
        send_column(random_column(DENSITY_DENSE), 1'b1);
        wait_for_results(SETTLE_CYCLES);
        write_register(cacs_pkg::REG_EARLY_PASS_LIMIT, 4);
    endtask

    // random frames under random registers; runs the pass count into saturation
    task automatic test_random_frames();
        int       first_item;
        int       len;
        density_t density;
        first_item = columns_sent;
        while (columns_sent - first_item < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_register(cacs_pkg::REG_ROWS_IN_USE, ($urandom_range(0, 7) == 0) ?
                               $urandom_range(0, 127) : $urandom_range(1, 64));
            if ($urandom_range(0, 3) == 0)
                write_register(cacs_pkg::REG_EARLY_PASS_LIMIT, $urandom_range(0, 15));
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            density = density_t'($urandom_range(0, 3));
            for (int i = 0; i < len; i++) begin
                // now and then drain the block in the middle of a frame
                if ($urandom_range(0, 15) == 0)
                    wait_for_results(0);
                send_column(random_column(density), i == len - 1);
            end
            wait_for_results(SETTLE_CYCLES);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // tready drops for a random stretch after each result transfer
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                stall_left = $urandom_range(0, recv_stall_max);
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_columns.size() == 0) begin
                $error("unexpected result transfer: next_column_cells %h frame_end %b",
                       m_tdata, m_tlast);
                mismatches++;
            end else begin
                due_column = pending_columns.pop_front();
                if (m_tdata !== due_column.cells) begin
                    $error("next_column_cells: expected %h, actual %h",
                           due_column.cells, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== due_column.frame_end) begin
                    $error("frame_end: expected %b, actual %b",
                           due_column.frame_end, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ends a hung run: counts cycles in which no transfer happens on either side
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = cacs_pkg::REG_ROWS_IN_USE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        history   = '0;
        seen      = '0;
        passes    = '0;
        rows_reg  = cacs_pkg::ROWS_IN_USE_RST;
        limit_reg = cacs_pkg::EARLY_PASS_LIMIT_RST;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_gap_max   = 2;
        recv_stall_max = 2;
        test_short_frames();
        test_row_count_extremes();
        test_early_limit_extremes();
        test_random_frames();

        wait_for_results(2 * SETTLE_CYCLES);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cacs_pkg.sv
hdl/cacs_col_eval.sv
hdl/cave_automaton_column_step.sv
tb/sv/testbench.sv
